// File: sv/ctia_pkg.sv
// Package for the connection table with idle aging.
// Holds sizes, action and status codes, the item and result beat types and
// the sequencer states. Depends on nothing.
package ctia_pkg;

  localparam int MAX_CONN      = 64;
  localparam int ID_SPACE      = 65536;
  localparam int SLOT_W        = $clog2(MAX_CONN);
  localparam int COUNT_W       = $clog2(MAX_CONN + 1);
  localparam int ID_W          = 16;
  localparam int STAMP_W       = 32;
  localparam int TIMEOUT_W     = 16;
  localparam int MS_PER_SECOND = 1000;
  localparam int LIMIT_W       = 26;
  localparam int TIMEOUT_RESET = 30;

  typedef enum logic [1:0] {
    ACT_SEEN   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SWEEP  = 2'd2,
    ACT_NONE   = 2'd3
  } ctia_action_t;

  typedef enum logic [2:0] {
    RS_ADDED     = 3'd0,
    RS_REFRESHED = 3'd1,
    RS_REMOVED   = 3'd2,
    RS_NOT_FOUND = 3'd3,
    RS_FULL      = 3'd4,
    RS_EVICTED   = 3'd5,
    RS_NONE_IDLE = 3'd6
  } ctia_status_t;

  typedef struct packed {
    ctia_action_t         action;
    logic [ID_W-1:0]      conn_id;
    logic [STAMP_W-1:0]   now_ms;
  } ctia_item_t;

  typedef struct packed {
    ctia_status_t         status;
    logic [ID_W-1:0]      result_id;
    logic [SLOT_W-1:0]    slot_index;
    logic [COUNT_W-1:0]   live_count;
    logic                 last_of_run;
  } ctia_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_MOVE,
    ST_SW_TEST,
    ST_SW_END
  } ctia_state_t;

endpackage

// File: sv/ctia_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot tables and the id-to-slot map; entries never written read
// as zero in simulation. No dependencies.
module ctia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  bit   [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/connection_table_idle_aging.sv
// Top level of the connection table with idle aging: sequencer, count and
// output register, around three ctia_ram instances.
// Depends on ctia_pkg and ctia_ram.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item's last result has been produced. A seen item takes a map
// read, a slot read and an update; a remove takes the same steps, plus a
// move step when the last entry must be moved into the freed slot. A sweep
// tests each live entry in turn, plus a move step per eviction that moves an
// entry; the single read port of the slot tables sets that pace. Each result
// beat is on out_data for exactly one cycle with out_valid high, in the cycle
// after it is decided (an eviction beat waits until the next eviction or the
// end of the walk is decided), and cannot be held off. The id-to-slot map is
// never cleared: a map entry counts only if its slot is below the live count
// and holds the same id. The idle limit is converted to milliseconds when the
// configuration beat is written; cfg_ready is always high.
module connection_table_idle_aging
  import ctia_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ctia_item_t            in_data,
  output logic                  out_valid,
  output ctia_result_t          out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIMEOUT_W-1:0]  cfg_data
);

  ctia_state_t          state_r, state_nxt;
  ctia_item_t           req_r, req_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [ID_W-1:0]      victim_r, victim_nxt;
  ctia_result_t         pend_r, pend_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ctia_result_t         out_data_r, out_data_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;

  logic [SLOT_W-1:0]    rd_addr;
  logic                 slot_we;
  logic [SLOT_W-1:0]    slot_waddr;
  logic [ID_W-1:0]      ids_wdata;
  logic [STAMP_W-1:0]   stamps_wdata;
  logic [ID_W-1:0]      ids_rdata;
  logic [STAMP_W-1:0]   stamps_rdata;
  logic                 map_we;
  logic [ID_W-1:0]      map_waddr;
  logic [SLOT_W-1:0]    map_wdata;
  logic [SLOT_W-1:0]    map_rdata;

  logic                 accept;
  logic                 hit;
  logic [SLOT_W-1:0]    last_slot;
  logic [COUNT_W-1:0]   count_dec;
  logic [STAMP_W-1:0]   elapsed;
  logic                 is_idle;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign last_slot = SLOT_W'(count_r - COUNT_W'(1));
  assign count_dec = count_r - COUNT_W'(1);
  assign hit       = ({1'b0, slot_r} < count_r) && (ids_rdata == req_r.conn_id);
  assign elapsed   = req_r.now_ms - stamps_rdata;
  assign is_idle   = elapsed > STAMP_W'(limit_r);

  assign limit_nxt = LIMIT_W'({10'd0, cfg_data} * LIMIT_W'(MS_PER_SECOND));

  ctia_ram #(.WIDTH(ID_W), .DEPTH(MAX_CONN)) u_ids (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (ids_wdata),
    .raddr (rd_addr),
    .rdata (ids_rdata)
  );

  ctia_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_CONN)) u_stamps (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (stamps_wdata),
    .raddr (rd_addr),
    .rdata (stamps_rdata)
  );

  ctia_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (in_data.conn_id),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      limit_r      <= LIMIT_W'(TIMEOUT_RESET * MS_PER_SECOND);
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= limit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    victim_r   <= victim_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    victim_nxt     = victim_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    rd_addr        = slot_r;
    slot_we        = 1'b0;
    slot_waddr     = slot_r;
    ids_wdata      = ids_rdata;
    stamps_wdata   = stamps_rdata;
    map_we         = 1'b0;
    map_waddr      = ids_rdata;
    map_wdata      = slot_r;

    case (state_r)
      ST_IDLE: begin
        rd_addr = last_slot;
        if (accept) begin
          req_nxt        = in_data;
          pend_valid_nxt = 1'b0;
          case (in_data.action)
            ACT_SEEN, ACT_REMOVE: begin
              state_nxt = ST_LOOKUP;
            end
            ACT_SWEEP: begin
              slot_nxt = last_slot;
              if (limit_r == '0 || count_r == '0) begin
                state_nxt = ST_SW_END;
              end else begin
                state_nxt = ST_SW_TEST;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        slot_nxt  = map_rdata;
        rd_addr   = map_rdata;
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        out_data_nxt.result_id   = req_r.conn_id;
        out_data_nxt.slot_index  = slot_r;
        out_data_nxt.live_count  = count_r;
        out_data_nxt.last_of_run = 1'b1;
        state_nxt                = ST_IDLE;
        if (req_r.action == ACT_SEEN) begin
          out_valid_nxt = 1'b1;
          if (hit) begin
            slot_we             = 1'b1;
            ids_wdata           = req_r.conn_id;
            stamps_wdata        = req_r.now_ms;
            out_data_nxt.status = RS_REFRESHED;
          end else if (count_r == COUNT_W'(MAX_CONN)) begin
            out_data_nxt.status     = RS_FULL;
            out_data_nxt.slot_index = '0;
          end else begin
            slot_we                 = 1'b1;
            slot_waddr              = SLOT_W'(count_r);
            ids_wdata               = req_r.conn_id;
            stamps_wdata            = req_r.now_ms;
            map_we                  = 1'b1;
            map_waddr               = req_r.conn_id;
            map_wdata               = SLOT_W'(count_r);
            count_nxt               = count_r + COUNT_W'(1);
            out_data_nxt.status     = RS_ADDED;
            out_data_nxt.slot_index = SLOT_W'(count_r);
            out_data_nxt.live_count = count_r + COUNT_W'(1);
          end
        end else if (!hit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = RS_NOT_FOUND;
          out_data_nxt.slot_index = '0;
        end else if (slot_r == last_slot) begin
          out_valid_nxt           = 1'b1;
          count_nxt               = count_dec;
          out_data_nxt.status     = RS_REMOVED;
          out_data_nxt.live_count = count_dec;
        end else begin
          // The last entry is read now and moved into the freed slot next.
          rd_addr   = last_slot;
          state_nxt = ST_MOVE;
        end
      end

      ST_MOVE: begin
        slot_we   = 1'b1;
        map_we    = 1'b1;
        count_nxt = count_dec;
        if (req_r.action == ACT_REMOVE) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = RS_REMOVED;
          out_data_nxt.result_id   = req_r.conn_id;
          out_data_nxt.slot_index  = slot_r;
          out_data_nxt.live_count  = count_dec;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = ST_IDLE;
        end else begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
          end
          pend_valid_nxt         = 1'b1;
          pend_nxt.status        = RS_EVICTED;
          pend_nxt.result_id     = victim_r;
          pend_nxt.slot_index    = slot_r;
          pend_nxt.live_count    = count_dec;
          pend_nxt.last_of_run   = 1'b0;
          if (slot_r == '0) begin
            state_nxt = ST_SW_END;
          end else begin
            slot_nxt  = slot_r - SLOT_W'(1);
            rd_addr   = slot_r - SLOT_W'(1);
            state_nxt = ST_SW_TEST;
          end
        end
      end

      ST_SW_TEST: begin
        if (is_idle && slot_r != last_slot) begin
          victim_nxt = ids_rdata;
          rd_addr    = last_slot;
          state_nxt  = ST_MOVE;
        end else begin
          // An eviction is held back until the next one or the end of the walk, so
          // that the final one can be marked as the last of the run.
          if (is_idle) begin
            count_nxt = count_dec;
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
            pend_valid_nxt       = 1'b1;
            pend_nxt.status      = RS_EVICTED;
            pend_nxt.result_id   = ids_rdata;
            pend_nxt.slot_index  = slot_r;
            pend_nxt.live_count  = count_dec;
            pend_nxt.last_of_run = 1'b0;
          end
          if (slot_r == '0) begin
            state_nxt = ST_SW_END;
          end else begin
            slot_nxt = slot_r - SLOT_W'(1);
            rd_addr  = slot_r - SLOT_W'(1);
          end
        end
      end

      ST_SW_END: begin
        out_valid_nxt = 1'b1;
        if (pend_valid_r) begin
          out_data_nxt             = pend_r;
          out_data_nxt.last_of_run = 1'b1;
        end else begin
          out_data_nxt.status      = RS_NONE_IDLE;
          out_data_nxt.result_id   = '0;
          out_data_nxt.slot_index  = '0;
          out_data_nxt.live_count  = count_r;
          out_data_nxt.last_of_run = 1'b1;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_CONN))
    else $error("live count exceeds the table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + COUNT_W'(1))
             || (count_r == $past(count_r) - COUNT_W'(1)))
    else $error("live count moved by more than one entry");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last_of_run) |-> busy)
    else $error("non-final result beat while the sequencer is idle");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid_r)
    else $error("result beat in the cycle after an item was taken");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_of_run) |-> (out_data_r.live_count == count_r))
    else $error("final result beat disagrees with the live count");

endmodule
